// ===== rtl/tpot_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpot_pkg
// Shared constants and types of the passive-open connection tracker.
// ----------------------------------------------------------------------------
package tpot_pkg;

  localparam int CONNECTIONS = 8;
  localparam int SLOT_W = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
  localparam int CNT_W = $clog2(CONNECTIONS + 1);

  localparam logic [31:0] INITIAL_SEQ = 32'h534D_1000;
  localparam logic [31:0] SEQ_STEP = 32'h0000_0101;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] FL_FIN = 8'h01;
  localparam logic [7:0] FL_SYN = 8'h02;
  localparam logic [7:0] FL_RST = 8'h04;
  localparam logic [7:0] FL_ACK = 8'h10;
  localparam logic [15:0] MIN_FRAME = 16'd54;
  localparam logic [15:0] ETH_HDR = 16'd14;

  localparam logic [2:0] ST_HANDLED = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_SHORT = 3'd2;
  localparam logic [2:0] ST_NOT_US = 3'd3;
  localparam logic [2:0] ST_BAD_IP = 3'd4;
  localparam logic [2:0] ST_BAD_LEN = 3'd5;
  localparam logic [2:0] ST_BAD_TCP = 3'd6;

  localparam logic [1:0] REG_LISTEN_EN = 2'd0;
  localparam logic [1:0] REG_LISTEN_PORT = 2'd1;
  localparam logic [1:0] REG_LOCAL_ADDR = 2'd2;

  typedef struct packed {
    logic [15:0] frame_length;
    logic [15:0] ether_type;
    logic [7:0]  version_ihl;
    logic [15:0] ip_total_length;
    logic [7:0]  ip_protocol;
    logic [31:0] src_address;
    logic [31:0] dst_address;
    logic [15:0] tcp_sport;
    logic [15:0] tcp_dport;
    logic [31:0] seq_number;
    logic [31:0] ack_number;
    logic [15:0] offset_and_flags;
  } hdr_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        reply_valid;
    logic [7:0]  reply_flags;
    logic [31:0] reply_seq;
    logic [31:0] reply_ack;
    logic [31:0] reply_dst_address;
    logic [15:0] reply_sport;
    logic [15:0] reply_dport;
    logic [2:0]  conn_slot;
    logic [3:0]  open_count;
  } res_t;

  // Checker to sequencer: header verdict and payload length.
  typedef struct packed {
    logic [2:0]  status;
    logic        pass;
    logic [15:0] payload;
  } chk_t;

endpackage

// ===== rtl/tpot_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpot_hdr_if / tpot_res_if
// Valid/ready channels for header items and result items.
// ----------------------------------------------------------------------------
interface tpot_hdr_if;
  import tpot_pkg::*;
  logic valid;
  logic ready;
  hdr_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tpot_res_if;
  import tpot_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/tpot_hdr_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpot_hdr_check
// Header validation: length, ethertype, IP header, clamped length, protocol, TCP offset, destination address.
// ----------------------------------------------------------------------------
module tpot_hdr_check (
  input  tpot_pkg::hdr_t hdr,
  input  logic [31:0]    local_address,
  output tpot_pkg::chk_t chk
);
  import tpot_pkg::*;

  logic [15:0] ip_avail;
  logic [15:0] ip_hlen;
  logic [15:0] tot;
  logic [15:0] tcp_avail;
  logic [15:0] tcp_hdr_len;

  always_comb begin
    ip_avail = hdr.frame_length - ETH_HDR;
    ip_hlen = {10'd0, hdr.version_ihl[3:0], 2'b00};
    tot = (hdr.ip_total_length > ip_avail) ? ip_avail : hdr.ip_total_length;
    tcp_avail = tot - ip_hlen;
    tcp_hdr_len = {10'd0, hdr.offset_and_flags[15:12], 2'b00};
    chk.payload = tcp_avail - tcp_hdr_len;
    chk.pass = 1'b0;
    priority if (hdr.frame_length == 16'd0) begin
      chk.status = ST_EMPTY;
    end else if (hdr.frame_length < MIN_FRAME || hdr.ether_type != ETHERTYPE_IPV4) begin
      chk.status = ST_SHORT;
    end else if (hdr.version_ihl[7:4] != 4'd4 || hdr.version_ihl[3:0] < 4'd5) begin
      chk.status = ST_BAD_IP;
    end else if (tot < ip_hlen + 16'd20) begin
      chk.status = ST_BAD_LEN;
    end else if (hdr.ip_protocol != PROTO_TCP) begin
      chk.status = ST_NOT_US;
    end else if (tcp_hdr_len < 16'd20 || tcp_hdr_len > tcp_avail) begin
      chk.status = ST_BAD_TCP;
    end else if (hdr.dst_address != local_address) begin
      chk.status = ST_NOT_US;
    end else begin
      chk.status = ST_HANDLED;
      chk.pass = 1'b1;
    end
  end
endmodule

// ===== rtl/tcp_passive_open_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_passive_open_tracker
// Passive-open TCP connection tracker with a serially searched slot table.
// ----------------------------------------------------------------------------
// Flow: an accepted header is registered, checked in S_CHECK, compared
//   with the slot table in S_SCAN (skipped if it fails the header checks),
//   acted on in S_ACT and held in S_OUT until the sink takes the result. A new
//   header is taken only in S_IDLE. The scan walks the table, one compare per cycle.
// Reset: synchronous active-low rst_n clears all slot-used bits, the
//   registers and the sequencer, and loads the initial sequence number.
// ----------------------------------------------------------------------------
module tcp_passive_open_tracker (
  input  logic                clk,
  input  logic                rst_n,
  tpot_hdr_if.sink            in_ch,
  tpot_res_if.source          out_ch,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [3:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  import tpot_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_ACT = 3'd3;
  localparam logic [2:0] S_OUT = 3'd4;

  logic [2:0] state_r, state_nxt;

  // Configuration registers.
  logic        listen_enable_r;
  logic [15:0] listen_port_r;
  logic [31:0] local_address_r;

  // Slot table: used bits reset, the rest written before read.
  logic [CONNECTIONS-1:0] used_r;
  logic [CONNECTIONS-1:0] estab_r;
  logic [31:0] peer_addr_r [CONNECTIONS];
  logic [31:0] own_addr_r  [CONNECTIONS];
  logic [15:0] peer_port_r [CONNECTIONS];
  logic [15:0] own_port_r  [CONNECTIONS];
  logic [31:0] snd_nxt_r   [CONNECTIONS];
  logic [31:0] rcv_nxt_r   [CONNECTIONS];
  logic [31:0] isn_r;

  hdr_t        hdr_r;
  chk_t        chk;
  chk_t        chk_r;
  logic [CNT_W-1:0] idx_r;
  logic [SLOT_W-1:0] cur;
  logic        hit_r, free_r;
  logic [SLOT_W-1:0] hit_idx_r, free_idx_r;
  logic [CNT_W-1:0] open_r, open_nxt;
  res_t        res_r, res_nxt;
  logic        out_valid_r;

  logic        cfg_wr;
  logic        match;
  logic [7:0]  flags;
  logic        fl_fin, fl_syn, fl_rst, fl_ack;
  logic [31:0] adv_sum;
  logic        do_estab, do_free, do_adv, do_open;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign flags = hdr_r.offset_and_flags[7:0];
  assign fl_fin = |(flags & FL_FIN);
  assign fl_syn = |(flags & FL_SYN);
  assign fl_rst = |(flags & FL_RST);
  assign fl_ack = |(flags & FL_ACK);
  assign cur = idx_r[SLOT_W-1:0];

  tpot_hdr_check u_check (
    .hdr           (hdr_r),
    .local_address (local_address_r),
    .chk           (chk)
  );

  // Read back registers.
  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_LISTEN_EN:   cfg_prdata = {31'd0, listen_enable_r};
      REG_LISTEN_PORT: cfg_prdata = {16'd0, listen_port_r};
      REG_LOCAL_ADDR:  cfg_prdata = local_address_r;
      default:         cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      listen_enable_r <= 1'b0;
      listen_port_r <= 16'd0;
      local_address_r <= 32'd0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_LISTEN_EN:   listen_enable_r <= cfg_pwdata[0];
        REG_LISTEN_PORT: listen_port_r <= cfg_pwdata[15:0];
        REG_LOCAL_ADDR:  local_address_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  // One table entry compared per cycle in the scan.
  assign match = used_r[cur] && peer_port_r[cur] == hdr_r.tcp_sport &&
                 own_port_r[cur] == hdr_r.tcp_dport &&
                 peer_addr_r[cur] == hdr_r.src_address &&
                 own_addr_r[cur] == hdr_r.dst_address;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_ch.valid) state_nxt = S_CHECK;
      S_CHECK: state_nxt = chk.pass ? S_SCAN : S_ACT;
      S_SCAN:  if (idx_r == CNT_W'(CONNECTIONS - 1)) state_nxt = S_ACT;
      S_ACT:   state_nxt = S_OUT;
      S_OUT:   if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Decide the table update and build the result once the scan is done.
  always_comb begin
    adv_sum = hdr_r.seq_number + 32'(chk_r.payload) + 32'(fl_fin);
    do_estab = 1'b0;
    do_free = 1'b0;
    do_adv = 1'b0;
    do_open = 1'b0;
    res_nxt = '0;
    res_nxt.status = chk_r.status;
    if (chk_r.pass) begin
      if (hit_r) begin
        res_nxt.conn_slot = 3'(hit_idx_r);
        if (!estab_r[hit_idx_r]) begin
          // Handshake: matching ACK establishes, RST drops the entry.
          if (fl_ack && !fl_syn && hdr_r.ack_number == snd_nxt_r[hit_idx_r]) begin
            do_estab = 1'b1;
          end else if (fl_rst) begin
            do_free = 1'b1;
          end
        end else if (chk_r.payload != 16'd0 || fl_fin) begin
          // Advance the receive number over payload and FIN, answer ACK.
          do_adv = 1'b1;
          do_free = fl_fin;
          res_nxt.reply_valid = 1'b1;
          res_nxt.reply_flags = FL_ACK;
          res_nxt.reply_seq = snd_nxt_r[hit_idx_r];
          res_nxt.reply_ack = adv_sum;
          res_nxt.reply_dst_address = hdr_r.src_address;
          res_nxt.reply_sport = hdr_r.tcp_dport;
          res_nxt.reply_dport = hdr_r.tcp_sport;
        end
      end else if (listen_enable_r && hdr_r.tcp_dport == listen_port_r &&
                   fl_syn && !fl_ack) begin
        // Open in the first free slot, or overwrite slot 0 when full.
        do_open = 1'b1;
        res_nxt.conn_slot = 3'(free_idx_r);
        res_nxt.reply_valid = 1'b1;
        res_nxt.reply_flags = FL_SYN | FL_ACK;
        res_nxt.reply_seq = isn_r;
        res_nxt.reply_ack = hdr_r.seq_number + 32'd1;
        res_nxt.reply_dst_address = hdr_r.src_address;
        res_nxt.reply_sport = hdr_r.tcp_dport;
        res_nxt.reply_dport = hdr_r.tcp_sport;
      end else begin
        res_nxt.status = ST_NOT_US;
      end
    end
    open_nxt = open_r;
    if (do_free) begin
      open_nxt = open_r - 1'b1;
    end else if (do_open && free_r) begin
      open_nxt = open_r + 1'b1;
    end
    res_nxt.open_count = 4'(open_nxt);
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r <= '0;
      isn_r <= INITIAL_SEQ;
      out_valid_r <= 1'b0;
      open_r <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: begin
          hdr_r <= in_ch.data;
        end
        S_CHECK: begin
          chk_r <= chk;
          idx_r <= '0;
          hit_r <= 1'b0;
          free_r <= 1'b0;
          hit_idx_r <= '0;
          free_idx_r <= '0;
        end
        S_SCAN: begin
          // Keep the first hit and the first free slot.
          if (match && !hit_r) begin
            hit_r <= 1'b1;
            hit_idx_r <= cur;
          end
          if (!used_r[cur] && !free_r) begin
            free_r <= 1'b1;
            free_idx_r <= cur;
          end
          idx_r <= idx_r + 1'b1;
        end
        S_ACT: begin
          res_r <= res_nxt;
          out_valid_r <= 1'b1;
          open_r <= open_nxt;
          if (do_estab) estab_r[hit_idx_r] <= 1'b1;
          if (do_free) used_r[hit_idx_r] <= 1'b0;
          if (do_adv) rcv_nxt_r[hit_idx_r] <= adv_sum;
          if (do_open) begin
            used_r[free_idx_r] <= 1'b1;
            estab_r[free_idx_r] <= 1'b0;
            peer_addr_r[free_idx_r] <= hdr_r.src_address;
            own_addr_r[free_idx_r] <= hdr_r.dst_address;
            peer_port_r[free_idx_r] <= hdr_r.tcp_sport;
            own_port_r[free_idx_r] <= hdr_r.tcp_dport;
            rcv_nxt_r[free_idx_r] <= hdr_r.seq_number + 32'd1;
            snd_nxt_r[free_idx_r] <= isn_r + 32'd1;
            isn_r <= isn_r + SEQ_STEP;
          end
        end
        S_OUT: begin
          // Hold the result until the sink takes it.
          if (out_ch.ready) out_valid_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Assertions.
  always_ff @(posedge clk) begin
    if (rst_n && state_r == S_IDLE) begin
      assert (open_r == CNT_W'($countones(used_r)))
        else $error("open count disagrees with used bits");
    end
  end

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ch.ready)
    else $error("accepting while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && state_r == S_OUT))
    else $error("result dropped while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (state_r == S_OUT || state_r == S_IDLE))
    else $error("result valid outside output phase");

endmodule

// ===== dv/tcp_passive_open_tracker_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_passive_open_tracker_tb
// Header frames are driven into the tracker and every result is compared
// with an in-bench connection table model. The run has a directed opening
// and then random connection traffic in several idle and config phases.
// ----------------------------------------------------------------------------
module tcp_passive_open_tracker_tb;
  import tpot_pkg::*;

  localparam int NPEERS = 12;

  // Track the connection table and hold the results the tracker owes us.
  class conn_scoreboard;
    bit          en;
    bit [15:0]   lport;
    bit [31:0]   laddr;
    bit          used[CONNECTIONS];
    bit          estab[CONNECTIONS];
    bit [31:0]   peer_ip[CONNECTIONS];
    bit [31:0]   own_ip[CONNECTIONS];
    bit [15:0]   peer_pt[CONNECTIONS];
    bit [15:0]   own_pt[CONNECTIONS];
    bit [31:0]   snd_nxt[CONNECTIONS];
    bit [31:0]   rcv_nxt[CONNECTIONS];
    bit [31:0]   isn;
    res_t        owed[$];
    int          errors;

    function new();
      isn = INITIAL_SEQ;
      foreach (used[i]) used[i] = 0;
    endfunction

    function int lookup(bit [31:0] src, bit [31:0] dst, bit [15:0] sp, bit [15:0] dp);
      for (int i = 0; i < CONNECTIONS; i++)
        if (used[i] && peer_pt[i] == sp && own_pt[i] == dp && peer_ip[i] == src &&
            own_ip[i] == dst) return i;
      return -1;
    endfunction

    task report(string msg);
      $display("%0t MISMATCH: %s", $time, msg);
      errors++;
    endtask

    // Compute the verdict and table update for one accepted header.
    function void note_header(hdr_t h);
      res_t     r;
      int       hit, s, ihl, tot, avail, thl, pay, adv, n;
      bit [7:0] fl;
      r = '0;
      fl = h.offset_and_flags[7:0];
      r.status = ST_NOT_US;
      if (h.frame_length == 0) begin
        r.status = ST_EMPTY;
      end else if (h.frame_length < MIN_FRAME || h.ether_type != ETHERTYPE_IPV4) begin
        r.status = ST_SHORT;
      end else begin
        avail = int'(h.frame_length) - 14;
        ihl = int'(h.version_ihl[3:0]) * 4;
        tot = int'(h.ip_total_length);
        if (tot > avail) tot = avail;
        thl = int'(h.offset_and_flags[15:12]) * 4;
        if (h.version_ihl[7:4] != 4'd4 || ihl < 20) r.status = ST_BAD_IP;
        else if (tot < ihl + 20) r.status = ST_BAD_LEN;
        else if (h.ip_protocol != PROTO_TCP) r.status = ST_NOT_US;
        else if (thl < 20 || thl > tot - ihl) r.status = ST_BAD_TCP;
        else if (h.dst_address != laddr) r.status = ST_NOT_US;
        else begin
          pay = tot - ihl - thl;
          hit = lookup(h.src_address, h.dst_address, h.tcp_sport, h.tcp_dport);
          if (hit >= 0) begin
            r.status = ST_HANDLED;
            r.conn_slot = hit[2:0];
            if (!estab[hit]) begin
              if ((fl & FL_ACK) != 0 && (fl & FL_SYN) == 0 && h.ack_number == snd_nxt[hit])
                estab[hit] = 1;
              else if ((fl & FL_RST) != 0)
                used[hit] = 0;
            end else begin
              adv = pay + (((fl & FL_FIN) != 0) ? 1 : 0);
              if (adv > 0) begin
                rcv_nxt[hit] = h.seq_number + adv;
                r.reply_valid = 1;
                r.reply_flags = FL_ACK;
                r.reply_seq = snd_nxt[hit];
                r.reply_ack = rcv_nxt[hit];
                if ((fl & FL_FIN) != 0) used[hit] = 0;
              end
            end
          end else if (en && h.tcp_dport == lport && (fl & FL_SYN) != 0 &&
                       (fl & FL_ACK) == 0) begin
            // Take the first free slot; a full table loses slot 0.
            s = 0;
            for (int i = CONNECTIONS - 1; i >= 0; i--) if (!used[i]) s = i;
            used[s] = 1;
            estab[s] = 0;
            peer_ip[s] = h.src_address;
            own_ip[s] = h.dst_address;
            peer_pt[s] = h.tcp_sport;
            own_pt[s] = h.tcp_dport;
            rcv_nxt[s] = h.seq_number + 1;
            snd_nxt[s] = isn + 1;
            r.status = ST_HANDLED;
            r.conn_slot = s[2:0];
            r.reply_valid = 1;
            r.reply_flags = FL_SYN | FL_ACK;
            r.reply_seq = isn;
            r.reply_ack = rcv_nxt[s];
            isn = isn + SEQ_STEP;
          end
        end
      end
      if (r.reply_valid) begin
        r.reply_dst_address = h.src_address;
        r.reply_sport = h.tcp_dport;
        r.reply_dport = h.tcp_sport;
      end
      n = 0;
      foreach (used[i]) n += used[i];
      r.open_count = n[3:0];
      owed.push_back(r);
    endfunction

    task cmp(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_result(res_t got);
      res_t e;
      if (owed.size() == 0) begin
        report("result with nothing expected");
        return;
      end
      e = owed.pop_front();
      cmp("status", got.status, e.status);
      cmp("reply_valid", got.reply_valid, e.reply_valid);
      cmp("reply_flags", got.reply_flags, e.reply_flags);
      cmp("reply_seq", got.reply_seq, e.reply_seq);
      cmp("reply_ack", got.reply_ack, e.reply_ack);
      cmp("reply_dst_address", got.reply_dst_address, e.reply_dst_address);
      cmp("reply_sport", got.reply_sport, e.reply_sport);
      cmp("reply_dport", got.reply_dport, e.reply_dport);
      cmp("conn_slot", got.conn_slot, e.conn_slot);
      cmp("open_count", got.open_count, e.open_count);
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic        cfg_pready;

  tpot_hdr_if hdr_ch ();
  tpot_res_if res_ch ();

  tcp_passive_open_tracker u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (hdr_ch),
    .out_ch      (res_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  conn_scoreboard sb;
  int             send_idle_pct;
  int             stall_pct;
  int             hold_cycles;
  bit [31:0]      peer_ip_pool[NPEERS];
  bit [15:0]      peer_pt_pool[NPEERS];

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Give up after a generous fixed time; a correct run needs well under 2 ms.
  initial begin
    #40ms;
    $display("Test completed with failures");
    $finish;
  end

  // Drive result ready: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      res_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Check every result transaction against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready) sb.check_result(res_ch.data);
  end

  // Offer one header, idling first at the phase's rate; note it once taken.
  task automatic send_hdr(hdr_t h);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      hdr_ch.valid <= 1'b0;
    end
    @(negedge clk);
    hdr_ch.valid <= 1'b1;
    hdr_ch.data <= h;
    @(posedge clk);
    while (!hdr_ch.ready) @(posedge clk);
    sb.note_header(h);
  endtask

  // Drop valid and wait until the tracker has nothing left to return.
  task automatic settle();
    @(negedge clk);
    hdr_ch.valid <= 1'b0;
    while (sb.owed.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_LISTEN_EN: sb.en = val[0];
      REG_LISTEN_PORT: sb.lport = val[15:0];
      default: sb.laddr = val;
    endcase
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic configure(bit en, bit [15:0] port, bit [31:0] addr);
    cfg_write(REG_LISTEN_EN, {31'd0, en});
    cfg_write(REG_LISTEN_PORT, {16'd0, port});
    cfg_write(REG_LOCAL_ADDR, addr);
  endtask

  // Build a well-formed TCP segment to us with the given payload size.
  function automatic hdr_t tcp_frame(bit [31:0] src, bit [15:0] sp, bit [15:0] dp,
                                     bit [7:0] fl, int pay);
    hdr_t h;
    int   ihl, off, tot;
    ihl = ($urandom_range(7) == 0) ? $urandom_range(15, 6) : 5;
    off = ($urandom_range(7) == 0) ? $urandom_range(15, 6) : 5;
    tot = ihl * 4 + off * 4 + pay;
    h.ether_type = ETHERTYPE_IPV4;
    h.version_ihl = {4'd4, 4'(ihl)};
    h.ip_total_length = 16'(tot);
    h.frame_length = 16'((tot + 14 < 54) ? 54 : tot + 14);
    // Sometimes claim more than the frame carries so the length is clamped.
    if ($urandom_range(5) == 0) h.ip_total_length = 16'(tot + $urandom_range(400));
    h.ip_protocol = PROTO_TCP;
    h.src_address = src;
    h.dst_address = sb.laddr;
    h.tcp_sport = sp;
    h.tcp_dport = dp;
    h.seq_number = $urandom;
    h.ack_number = $urandom;
    h.offset_and_flags = {4'(off), 4'($urandom), fl};
    return h;
  endfunction

  // Segment from a pool peer, aimed at its open slot where there is one.
  function automatic hdr_t peer_frame(int p, bit [7:0] fl, int pay);
    hdr_t h;
    int   s;
    bit [15:0] dp;
    s = -1;
    dp = sb.lport;
    for (int i = 0; i < CONNECTIONS && s < 0; i++)
      if (sb.used[i] && sb.peer_ip[i] == peer_ip_pool[p] && sb.peer_pt[i] == peer_pt_pool[p] &&
          sb.own_ip[i] == sb.laddr) s = i;
    if (s >= 0 && (fl & FL_SYN) == 0) dp = sb.own_pt[s];
    h = tcp_frame(peer_ip_pool[p], peer_pt_pool[p], dp, fl, pay);
    if (s >= 0) begin
      if ($urandom_range(7) != 0) h.ack_number = sb.snd_nxt[s];
      if ($urandom_range(3) != 0) h.seq_number = sb.rcv_nxt[s];
    end
    return h;
  endfunction

  function automatic hdr_t noise_frame();
    hdr_t h;
    h.frame_length = 16'($urandom);
    h.ether_type = 16'($urandom);
    h.version_ihl = 8'($urandom);
    h.ip_total_length = 16'($urandom);
    h.ip_protocol = 8'($urandom);
    h.src_address = $urandom;
    h.dst_address = $urandom;
    h.tcp_sport = 16'($urandom);
    h.tcp_dport = 16'($urandom);
    h.seq_number = $urandom;
    h.ack_number = $urandom;
    h.offset_and_flags = 16'($urandom);
    return h;
  endfunction

  // Break exactly one header check of an otherwise good segment.
  function automatic hdr_t broken_frame(int which);
    hdr_t h;
    h = peer_frame($urandom_range(NPEERS - 1), FL_ACK, $urandom_range(40));
    case (which)
      0: h.frame_length = 0;
      1: h.frame_length = 16'($urandom_range(53, 1));
      2: h.ether_type = 16'h86DD;
      3: h.version_ihl[7:4] = ($urandom_range(1)) ? 4'd6 : 4'(~4'd4);
      4: h.version_ihl[3:0] = 4'($urandom_range(4));
      5: h.ip_total_length = 16'($urandom_range(39));
      6: h.ip_protocol = ($urandom_range(1)) ? 8'd17 : 8'hFF;
      7: h.offset_and_flags[15:12] = 4'($urandom_range(4));
      8: h.offset_and_flags[15:12] = 4'hF;
      default: h.dst_address = ~sb.laddr;
    endcase
    return h;
  endfunction

  function automatic hdr_t random_frame();
    int k, p, pay;
    k = $urandom_range(99);
    p = $urandom_range(NPEERS - 1);
    pay = ($urandom_range(9) == 0) ? $urandom_range(1400) : $urandom_range(60);
    if (k < 22) return peer_frame(p, FL_SYN | 8'($urandom_range(1) ? 0 : 8'hE0), pay);
    if (k < 42) return peer_frame(p, FL_ACK, 0);
    if (k < 64) return peer_frame(p, FL_ACK | 8'($urandom_range(1) ? 8'h08 : 0), pay);
    if (k < 72) return peer_frame(p, FL_ACK | FL_FIN, pay);
    if (k < 77) return peer_frame(p, FL_RST, 0);
    if (k < 84) return peer_frame(p, 8'($urandom), pay);
    if (k < 92) return broken_frame($urandom_range(9));
    return noise_frame();
  endfunction

  task automatic directed();
    hdr_t h;
    configure(1'b1, 16'd80, 32'hC0A8_0001);
    for (int i = 0; i < 10; i++) send_hdr(broken_frame(i));
    // Open, refuse a bad ack, establish, carry data, close with FIN.
    send_hdr(peer_frame(0, FL_SYN, 0));
    h = peer_frame(0, FL_ACK, 0);
    h.ack_number = h.ack_number + 1;
    send_hdr(h);
    send_hdr(peer_frame(0, FL_ACK, 0));
    send_hdr(peer_frame(0, FL_ACK, 0));
    send_hdr(peer_frame(0, FL_ACK, 100));
    send_hdr(peer_frame(0, FL_ACK | FL_FIN, 0));
    // Reset a half-open entry, then fill the table and overwrite slot 0.
    send_hdr(peer_frame(1, FL_SYN, 0));
    send_hdr(peer_frame(1, FL_RST, 0));
    for (int p = 2; p < 11; p++) send_hdr(peer_frame(p, FL_SYN, 0));
    send_hdr(peer_frame(11, FL_ACK, 0));
  endtask

  initial begin
    bit [15:0] ports[6];
    bit [31:0] addrs[6];
    bit        ens[6];
    sb = new();
    rst_n = 0;
    hdr_ch.valid = 0;
    hdr_ch.data = '0;
    res_ch.ready = 0;
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 0;
    for (int p = 0; p < NPEERS; p++) begin
      peer_ip_pool[p] = $urandom;
      peer_pt_pool[p] = 16'($urandom);
    end
    peer_ip_pool[1] = 32'hFFFF_FFFF;
    peer_pt_pool[1] = 16'hFFFF;
    peer_ip_pool[2] = 32'h0;
    peer_pt_pool[2] = 16'h0;
    ens = '{1, 1, 1, 0, 1, 1};
    ports = '{16'd0, 16'hFFFF, 16'd443, 16'd80, 16'd8080, 16'd0};
    addrs = '{32'h0, 32'hFFFF_FFFF, 32'h0A00_0002, 32'h0A00_0002, $urandom, 32'hC0A8_0001};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    directed();
    settle();
    for (int ph = 0; ph < 6; ph++) begin
      configure(ens[ph], ports[ph], addrs[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 79; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 79; end
        default: begin send_idle_pct = 7; stall_pct = 7; end
      endcase
      for (int n = 0; n < 240; n++) begin
        // Hold off results for a long stretch; the tracker must stall its header input.
        if (ph == 0 && n == 60) hold_cycles = 400;
        send_hdr(random_frame());
      end
      settle();
    end
    repeat (30) @(posedge clk);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
